FILE: rtl/ilpa_pkg.sv
// ilpa_pkg: shared types, codes and constants of the interrupt line pool allocator
// no dependencies; used by the interfaces, controller, datapath and top level

package ilpa_pkg;

	// fixed geometry
	localparam int NUM_LINES   = 32;
	localparam int MAX_SOURCES = 128;
	localparam int POOL_SIZE   = 7;
	localparam int POOL_IDX_W  = 3;
	localparam int LINE_W      = 5;
	localparam int SRC_W       = 7;
	localparam int ROUTE_W     = 8;
	localparam int MASK_W      = 32;

	// line a detached source is routed to
	localparam logic [LINE_W-1:0] DETACH_LINE = 5'd16;

	// configuration reset values
	localparam logic [7:0]  SOURCE_COUNT_RST = 8'd69;
	localparam logic [31:0] MAP_BASE_RST     = 32'd0;
	localparam logic [15:0] MAP_STRIDE_RST   = 16'd4;

	typedef enum logic [1:0] {
		REQ_ENABLE   = 2'd0,
		REQ_DISABLE  = 2'd1,
		REQ_DISPATCH = 2'd2
	} req_code_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_EXHAUSTED = 2'd2
	} status_code_t;

	typedef enum logic [1:0] {
		CFG_SOURCE_COUNT = 2'd0,
		CFG_MAP_BASE     = 2'd1,
		CFG_MAP_STRIDE   = 2'd2
	} cfg_index_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_state_t;

	// request payload
	typedef struct packed {
		logic [1:0]        req_type;
		logic [SRC_W-1:0]  source;
		logic [LINE_W-1:0] cpu_line;
		logic              handler_present;
	} req_t;

	// result payload
	typedef struct packed {
		logic [1:0]        status;
		logic [LINE_W-1:0] assigned_line;
		logic              map_write;
		logic [31:0]       map_address;
		logic [LINE_W-1:0] map_value;
		logic [MASK_W-1:0] enable_mask;
		logic              call_handler;
		logic [SRC_W-1:0]  handler_source;
		logic              line_masked;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	// cpu line served by each pool slot, in search order
	function automatic logic [LINE_W-1:0] pool_line(input logic [POOL_IDX_W-1:0] idx);
		logic [LINE_W-1:0] line;
		case (idx)
			3'd0: line = 5'd12;
			3'd1: line = 5'd13;
			3'd2: line = 5'd17;
			3'd3: line = 5'd18;
			3'd4: line = 5'd9;
			3'd5: line = 5'd2;
			3'd6: line = 5'd3;
			default: line = 5'd0;
		endcase
		return line;
	endfunction

	// a pool slot is usable only if its line exists on this core
	function automatic logic pool_usable(input logic [POOL_IDX_W-1:0] idx);
		return ({27'd0, pool_line(idx)} < 32'(NUM_LINES)) && ({29'd0, idx} < 32'(POOL_SIZE));
	endfunction

endpackage

FILE: rtl/ilpa_req_if.sv
// ilpa_req_if: valid/ready channel carrying one request item
// depends on ilpa_pkg for field widths

interface ilpa_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    req_type;
	logic [ilpa_pkg::SRC_W-1:0]    source_id;
	logic [ilpa_pkg::LINE_W-1:0]   cpu_line;
	logic                          handler_present;

	modport source (output valid, req_type, source_id, cpu_line, handler_present, input ready);
	modport sink   (input valid, req_type, source_id, cpu_line, handler_present, output ready);
endinterface

FILE: rtl/ilpa_rsp_if.sv
// ilpa_rsp_if: valid/ready channel carrying one result item
// depends on ilpa_pkg for field widths

interface ilpa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic [ilpa_pkg::LINE_W-1:0]   assigned_line;
	logic                          map_write;
	logic [31:0]                   map_address;
	logic [ilpa_pkg::LINE_W-1:0]   map_value;
	logic [ilpa_pkg::MASK_W-1:0]   enable_mask;
	logic                          call_handler;
	logic [ilpa_pkg::SRC_W-1:0]    handler_source;
	logic                          line_masked;

	modport source (output valid, status, assigned_line, map_write, map_address, map_value,
		enable_mask, call_handler, handler_source, line_masked, input ready);
	modport sink   (input valid, status, assigned_line, map_write, map_address, map_value,
		enable_mask, call_handler, handler_source, line_masked, output ready);
endinterface

FILE: rtl/ilpa_ctrl.sv
// ilpa_ctrl: request sequencer and result valid flag
// depends on ilpa_pkg (state enum, command struct)

module ilpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ilpa_pkg::cmd_t    cmd
);

	ilpa_pkg::fsm_state_t state_q;
	ilpa_pkg::fsm_state_t state_d;
	logic                 out_valid_q;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ilpa_pkg::FSM_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = ilpa_pkg::FSM_EXEC;
				end
			end
			ilpa_pkg::FSM_EXEC: begin
				// result register free or being emptied this cycle
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = ilpa_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = ilpa_pkg::FSM_IDLE;
			end
		endcase
	end

	// state register and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ilpa_pkg::FSM_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/ilpa_dp.sv
// ilpa_dp: configuration registers, pool route table, enable mask and result register
// depends on ilpa_pkg (types, pool table, codes)

module ilpa_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  ilpa_pkg::cmd_t       cmd,
	input  ilpa_pkg::req_t       req,
	output ilpa_pkg::rsp_t       rsp
);

	localparam int PW = ilpa_pkg::POOL_IDX_W;

	logic [7:0]  source_count_q;
	logic [31:0] map_base_q;
	logic [15:0] map_stride_q;

	// route per pool slot: source + 1, zero when free
	logic [ilpa_pkg::ROUTE_W-1:0] route_q [ilpa_pkg::POOL_SIZE];
	logic [ilpa_pkg::MASK_W-1:0]  enable_q;
	ilpa_pkg::req_t               req_q;
	ilpa_pkg::rsp_t               rsp_q;

	logic [ilpa_pkg::ROUTE_W-1:0] tag;
	logic                         hit;
	logic [PW-1:0]                hit_idx;
	logic                         free_found;
	logic [PW-1:0]                free_idx;
	logic                         disp_hit;
	logic [ilpa_pkg::ROUTE_W-1:0] disp_route;
	logic                         range_err;
	logic [22:0]                  stride_prod;
	logic [31:0]                  route_addr;
	logic                         set_route;
	logic                         clr_route;
	logic [PW-1:0]                upd_idx;
	logic [ilpa_pkg::LINE_W-1:0]  upd_line;
	logic [ilpa_pkg::MASK_W-1:0]  enable_d;
	ilpa_pkg::rsp_t               rsp_d;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_count_q <= ilpa_pkg::SOURCE_COUNT_RST;
			map_base_q     <= ilpa_pkg::MAP_BASE_RST;
			map_stride_q   <= ilpa_pkg::MAP_STRIDE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ilpa_pkg::CFG_SOURCE_COUNT: source_count_q <= cfg_data[7:0];
				ilpa_pkg::CFG_MAP_BASE:     map_base_q     <= cfg_data;
				ilpa_pkg::CFG_MAP_STRIDE:   map_stride_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// pool search: first slot already serving the source, first free slot,
	// and the slot behind the dispatched line
	always_comb begin
		tag        = {1'b0, req_q.source} + 8'd1;
		hit        = 1'b0;
		hit_idx    = '0;
		free_found = 1'b0;
		free_idx   = '0;
		disp_hit   = 1'b0;
		disp_route = '0;
		for (int i = 0; i < ilpa_pkg::POOL_SIZE; i++) begin
			if (ilpa_pkg::pool_usable(PW'(i))) begin
				if (!hit && route_q[i] == tag) begin
					hit     = 1'b1;
					hit_idx = PW'(i);
				end
				if (!free_found && route_q[i] == '0) begin
					free_found = 1'b1;
					free_idx   = PW'(i);
				end
				if (ilpa_pkg::pool_line(PW'(i)) == req_q.cpu_line) begin
					disp_hit   = 1'b1;
					disp_route = route_q[i];
				end
			end
		end
	end

	// routing register address
	assign stride_prod = map_stride_q * req_q.source;
	assign route_addr  = map_base_q + {9'd0, stride_prod};
	assign range_err   = ({1'b0, req_q.source} >= source_count_q) ||
		({1'b0, req_q.source} >= 8'(ilpa_pkg::MAX_SOURCES));

	// request evaluation
	always_comb begin
		rsp_d     = '0;
		enable_d  = enable_q;
		set_route = 1'b0;
		clr_route = 1'b0;
		upd_idx   = hit ? hit_idx : free_idx;
		upd_line  = ilpa_pkg::pool_line(upd_idx);
		case (req_q.req_type)
			ilpa_pkg::REQ_ENABLE: begin
				if (range_err) begin
					rsp_d.status = ilpa_pkg::ST_RANGE;
				end else if (!hit && !free_found) begin
					rsp_d.status = ilpa_pkg::ST_EXHAUSTED;
				end else begin
					set_route           = 1'b1;
					enable_d            = enable_q | (32'd1 << upd_line);
					rsp_d.assigned_line = upd_line;
					rsp_d.map_write     = 1'b1;
					rsp_d.map_address   = route_addr;
					rsp_d.map_value     = upd_line;
				end
			end
			ilpa_pkg::REQ_DISABLE: begin
				upd_idx  = hit_idx;
				upd_line = ilpa_pkg::pool_line(hit_idx);
				if (range_err) begin
					rsp_d.status = ilpa_pkg::ST_RANGE;
				end else if (hit) begin
					clr_route           = 1'b1;
					enable_d            = enable_q & ~(32'd1 << upd_line);
					rsp_d.assigned_line = upd_line;
					rsp_d.map_write     = 1'b1;
					rsp_d.map_address   = route_addr;
					rsp_d.map_value     = ilpa_pkg::DETACH_LINE;
				end
			end
			ilpa_pkg::REQ_DISPATCH: begin
				rsp_d.assigned_line = req_q.cpu_line;
				if (disp_hit && disp_route != '0 && req_q.handler_present) begin
					rsp_d.call_handler   = 1'b1;
					rsp_d.handler_source = ilpa_pkg::SRC_W'(disp_route - 8'd1);
				end else begin
					enable_d          = enable_q & ~(32'd1 << req_q.cpu_line);
					rsp_d.line_masked = 1'b1;
				end
			end
			default: ;
		endcase
		rsp_d.enable_mask = enable_d;
	end

	// route table and enable mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '0;
			for (int i = 0; i < ilpa_pkg::POOL_SIZE; i++) begin
				route_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			enable_q <= enable_d;
			if (set_route) begin
				route_q[upd_idx] <= tag;
			end else if (clr_route) begin
				route_q[upd_idx] <= '0;
			end
		end
	end

	// request capture and result register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

FILE: rtl/interrupt_line_pool_allocator.sv
// interrupt_line_pool_allocator: top level joining controller and datapath
// depends on ilpa_pkg, ilpa_req_if, ilpa_rsp_if, ilpa_ctrl, ilpa_dp
//
// Usage:
//   req channel: one request item (enable, disable or dispatch) per handshake.
//   rsp channel: exactly one result item per request, in request order.
//   cfg port: the user must write source_count, map_base and map_stride
//   via cfg_we/cfg_index/cfg_data while idle (unenforced); index 3 is ignored.
// Timing:
//   a request is accepted in the idle state, evaluated against the seven-slot
//   pool and committed in the exec state once the result register is free or
//   being emptied; the commit registers the result. The two-state request
//   sequencer takes no new request until that commit.
// Reset:
//   arst_n clears all routes, the enable mask and the result flag and loads
//   the configuration reset values (69 sources, base 0, stride 4).
// Stalls:
//   a finished result waits in the output register while rsp.ready is low;
//   one further request is taken meanwhile and held until the result leaves.

module interrupt_line_pool_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	ilpa_req_if.sink    req,
	ilpa_rsp_if.source  rsp
);

	ilpa_pkg::cmd_t cmd;
	ilpa_pkg::req_t req_item;
	ilpa_pkg::rsp_t rsp_item;

	// pack request fields
	assign req_item.req_type        = req.req_type;
	assign req_item.source          = req.source_id;
	assign req_item.cpu_line        = req.cpu_line;
	assign req_item.handler_present = req.handler_present;

	// sequencer
	ilpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// tables and result register
	ilpa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.req       (req_item),
		.rsp       (rsp_item)
	);

	// unpack result fields
	assign rsp.status         = rsp_item.status;
	assign rsp.assigned_line  = rsp_item.assigned_line;
	assign rsp.map_write      = rsp_item.map_write;
	assign rsp.map_address    = rsp_item.map_address;
	assign rsp.map_value      = rsp_item.map_value;
	assign rsp.enable_mask    = rsp_item.enable_mask;
	assign rsp.call_handler   = rsp_item.call_handler;
	assign rsp.handler_source = rsp_item.handler_source;
	assign rsp.line_masked    = rsp_item.line_masked;

endmodule

FILE: test/ilpa_result_checker.sv
`timescale 1ns / 1ps
// ilpa_result_checker: watches the request, result and register write ports of the allocator,
// keeps its own copy of the route table and enable mask and compares every result item
// depends on ilpa_pkg, ilpa_req_if and ilpa_rsp_if

module ilpa_result_checker
	import ilpa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	ilpa_req_if         req,
	ilpa_rsp_if         rsp,
	output int          fail_count,
	output int          outstanding
);

	// pool lines in search order, lowest slot in the low bits
	localparam logic [POOL_SIZE*LINE_W-1:0] POOL_LINES =
		{5'd3, 5'd2, 5'd9, 5'd18, 5'd17, 5'd13, 5'd12};

	// mirrored block state: owner of each line is source + 1, zero when free
	logic [ROUTE_W-1:0] line_owner [NUM_LINES];
	logic [MASK_W-1:0]  mask_bits;
	logic [7:0]         src_limit;
	logic [31:0]        base_addr;
	logic [15:0]        addr_stride;

	rsp_t awaited_results [$];
	int   mismatch_count = 0;

	assign fail_count = mismatch_count;

	// routing register address of a source, wrapping at 32 bits
	function automatic logic [31:0] route_addr(input logic [SRC_W-1:0] src);
		return base_addr + {16'd0, addr_stride} * {25'd0, src};
	endfunction

	// apply one request to the mirrored state and return its result item
	function automatic rsp_t serve_request(input logic [1:0] kind, input logic [SRC_W-1:0] src,
		input logic [LINE_W-1:0] line, input logic hp);
		rsp_t               r;
		logic [LINE_W-1:0]  cand;
		logic [LINE_W-1:0]  pick;
		logic               have;
		logic               owned;
		logic [ROUTE_W-1:0] tag;
		r = '0;
		pick = '0;
		have = 1'b0;
		owned = 1'b0;
		tag = {1'b0, src} + 8'd1;
		if (kind == REQ_ENABLE || kind == REQ_DISABLE) begin
			if ({1'b0, src} >= src_limit || int'(src) >= MAX_SOURCES) begin
				r.status = ST_RANGE;
			end else if (kind == REQ_ENABLE) begin
				// an existing route wins over the first free line
				for (int i = 0; i < POOL_SIZE; i++) begin
					cand = POOL_LINES[i*LINE_W +: LINE_W];
					if (!owned && int'(cand) < NUM_LINES) begin
						if (line_owner[cand] == tag) begin
							pick = cand;
							have = 1'b1;
							owned = 1'b1;
						end else if (!have && line_owner[cand] == '0) begin
							pick = cand;
							have = 1'b1;
						end
					end
				end
				if (!have) begin
					r.status = ST_EXHAUSTED;
				end else begin
					line_owner[pick] = tag;
					mask_bits[pick] = 1'b1;
					r.assigned_line = pick;
					r.map_write = 1'b1;
					r.map_address = route_addr(src);
					r.map_value = pick;
				end
			end else begin
				// release the first pool line owned by the source
				for (int i = 0; i < POOL_SIZE; i++) begin
					cand = POOL_LINES[i*LINE_W +: LINE_W];
					if (!owned && int'(cand) < NUM_LINES && line_owner[cand] == tag) begin
						mask_bits[cand] = 1'b0;
						line_owner[cand] = '0;
						r.assigned_line = cand;
						r.map_write = 1'b1;
						r.map_address = route_addr(src);
						r.map_value = DETACH_LINE;
						owned = 1'b1;
					end
				end
			end
		end else if (kind == REQ_DISPATCH) begin
			r.assigned_line = line;
			if (int'(line) < NUM_LINES && line_owner[line] != '0 && hp) begin
				r.call_handler = 1'b1;
				r.handler_source = SRC_W'(line_owner[line] - 8'd1);
			end else begin
				mask_bits[line] = 1'b0;
				r.line_masked = 1'b1;
			end
		end
		r.enable_mask = mask_bits;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// follow writes, predict on each accepted request, compare on each accepted result
	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_LINES; i++)
				line_owner[i] = '0;
			mask_bits = '0;
			src_limit = SOURCE_COUNT_RST;
			base_addr = MAP_BASE_RST;
			addr_stride = MAP_STRIDE_RST;
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SOURCE_COUNT: src_limit = cfg_data[7:0];
					CFG_MAP_BASE:     base_addr = cfg_data;
					CFG_MAP_STRIDE:   addr_stride = cfg_data[15:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				awaited_results.push_back(serve_request(req.req_type, req.source_id,
					req.cpu_line, req.handler_present));
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					$error("result item with no request waiting");
					mismatch_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("status", 32'(want.status), 32'(rsp.status));
					check_field("assigned_line", 32'(want.assigned_line),
						32'(rsp.assigned_line));
					check_field("map_write", 32'(want.map_write), 32'(rsp.map_write));
					check_field("map_address", want.map_address, rsp.map_address);
					check_field("map_value", 32'(want.map_value), 32'(rsp.map_value));
					check_field("enable_mask", want.enable_mask, rsp.enable_mask);
					check_field("call_handler", 32'(want.call_handler),
						32'(rsp.call_handler));
					check_field("handler_source", 32'(want.handler_source),
						32'(rsp.handler_source));
					check_field("line_masked", 32'(want.line_masked), 32'(rsp.line_masked));
				end
			end
			outstanding <= awaited_results.size();
		end
	end

endmodule

FILE: test/interrupt_line_pool_allocator_tb.sv
`timescale 1ns / 1ps
// interrupt_line_pool_allocator_tb: drives requests and register writes into the allocator,
// stalls the result side at random and gives the verdict from the checker's failure count
// depends on ilpa_pkg, ilpa_req_if, ilpa_rsp_if, ilpa_result_checker and the block itself

module interrupt_line_pool_allocator_tb;
	import ilpa_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [POOL_SIZE*LINE_W-1:0] POOL_LINES =
		{5'd3, 5'd2, 5'd9, 5'd18, 5'd17, 5'd13, 5'd12};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	bit          calm;
	int          fail_count;
	int          outstanding;
	int unsigned cycle_count = 0;

	ilpa_req_if req_ch ();
	ilpa_rsp_if rsp_ch ();

	interrupt_line_pool_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	ilpa_result_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #10 clk = ~clk;

	// result side stalls at random, ready low with a chance of 17 in a hundred, unless calm
	always @(posedge clk) begin
		rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 17);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// hand one request item over, with random idle cycles before it
	task automatic send_request(input logic [1:0] kind, input logic [SRC_W-1:0] src,
		input logic [LINE_W-1:0] line, input logic hp);
		while (!calm && $urandom_range(0, 99) < 17) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.source_id <= src;
		req_ch.cpu_line <= line;
		req_ch.handler_present <= hp;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// wait until every result is back and the block has gone quiet
	task automatic settle_idle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all three registers on successive edges
	task automatic load_settings(input logic [7:0] count, input logic [31:0] base,
		input logic [15:0] stride);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SOURCE_COUNT;
		cfg_data <= {24'd0, count};
		@(posedge clk);
		cfg_index <= CFG_MAP_BASE;
		cfg_data <= base;
		@(posedge clk);
		cfg_index <= CFG_MAP_STRIDE;
		cfg_data <= {16'd0, stride};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly a small cluster of sources and the pool lines, so the pool fills and drains
	task automatic random_request(input int unsigned lo);
		int unsigned       roll;
		logic [1:0]        kind;
		logic [SRC_W-1:0]  src;
		logic [LINE_W-1:0] line;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			kind = REQ_ENABLE;
		else if (roll < 62)
			kind = REQ_DISABLE;
		else if (roll < 96)
			kind = REQ_DISPATCH;
		else
			kind = 2'($urandom);
		if ($urandom_range(0, 99) < 80)
			src = SRC_W'(lo + $urandom_range(0, 9));
		else
			src = SRC_W'($urandom);
		if ($urandom_range(0, 99) < 70)
			line = POOL_LINES[$urandom_range(0, POOL_SIZE-1)*LINE_W +: LINE_W];
		else
			line = LINE_W'($urandom);
		send_request(kind, src, line, $urandom_range(0, 99) < 75);
	endtask

	initial begin : stimulus
		int unsigned lim;
		int unsigned lo;
		int          count;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SOURCE_COUNT;
		cfg_data = '0;
		calm = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_ENABLE;
		req_ch.source_id = '0;
		req_ch.cpu_line = '0;
		req_ch.handler_present = 1'b0;
		rsp_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset settings
		send_request(REQ_DISPATCH, 7'd0, 5'd0, 1'b1);     // unattached line gets masked
		send_request(REQ_ENABLE, 7'd0, 5'd0, 1'b0);       // first pool line
		send_request(REQ_ENABLE, 7'd68, 5'd31, 1'b1);     // highest source in range
		send_request(REQ_ENABLE, 7'd69, 5'd0, 1'b0);      // just out of range
		send_request(REQ_ENABLE, 7'd127, 5'd31, 1'b1);    // far out of range
		send_request(REQ_ENABLE, 7'd0, 5'd0, 1'b0);       // reuse of an existing route
		for (int s = 1; s <= 5; s++)
			send_request(REQ_ENABLE, SRC_W'(s), 5'd0, 1'b0);
		send_request(REQ_ENABLE, 7'd6, 5'd0, 1'b0);       // pool exhausted
		send_request(REQ_DISPATCH, 7'd0, 5'd12, 1'b1);    // handler call
		send_request(REQ_DISPATCH, 7'd0, 5'd13, 1'b0);    // attached but no handler
		send_request(REQ_DISPATCH, 7'd127, 5'd31, 1'b1);  // unattached top line
		send_request(REQ_DISABLE, 7'd68, 5'd0, 1'b0);     // release a line
		send_request(REQ_DISABLE, 7'd68, 5'd0, 1'b0);     // source no longer routed
		send_request(REQ_DISABLE, 7'd100, 5'd0, 1'b0);    // out of range
		send_request(2'd3, 7'd127, 5'd31, 1'b1);          // unknown request type
		send_request(REQ_ENABLE, 7'd6, 5'd0, 1'b0);       // takes the freed line
		send_request(REQ_DISPATCH, 7'd0, 5'd13, 1'b1);
		settle_idle();

		// random phases, each under its own settings; the third has no idling
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: load_settings(8'd128, 32'hFFFF_FFFF, 16'hFFFF);
				1: load_settings(8'd0, 32'd0, 16'd0);
				2: load_settings(8'd255, $urandom, 16'($urandom));
				3: load_settings(8'd1, $urandom, 16'd1);
				default: load_settings(8'($urandom), $urandom, 16'($urandom));
			endcase
			calm = (p == 2);
			lim = (p == 0) ? 128 : (p == 1) ? 0 : (p == 2) ? 128 : (p == 3) ? 1 : 64;
			lo = (lim > 10) ? $urandom_range(0, lim - 10) : 0;
			count = (p == 1) ? 60 : 254;
			for (int n = 0; n < count; n++)
				random_request(lo);
			settle_idle();
			calm = 1'b0;
		end

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
